// ===== rtl/nearest_palette_color_search_core_macros.svh =====
// Assertion macros shared by the nearest palette colour search RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_CORE_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define NPCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NPCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPCS_ASSERT(lbl, prop, msg)
`define NPCS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/npcs_pkg.sv =====
// Package for the nearest palette colour search core: widths, codes, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package npcs_pkg;

  localparam int CH_W                = 8;
  localparam int IDX_W               = 8;
  localparam int DIST_W              = 10;
  localparam int FUNC_W              = 2;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int INDEX_REACH         = 256;
  localparam logic [CH_W-1:0] DARKEN_RESET = 8'd80;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEAREST = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DARKEN  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } npcs_rgb_t;

  typedef struct packed {
    logic             clear;
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } npcs_scan_ctl_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CH_W-1:0] sat_sub(input logic [CH_W-1:0] v,
                                              input logic [CH_W-1:0] amt);
    sat_sub = (v > amt) ? (v - amt) : '0;
  endfunction

endpackage

// ===== rtl/npcs_if.sv =====
// Handshake channel interfaces: input word, result word and configuration write.
// Depends on npcs_pkg.
`timescale 1ns / 1ps
interface npcs_in_if;
  import npcs_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  entry_index;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;
  modport source(output valid, func, entry_index, red, green, blue, input ready);
  modport sink(input valid, func, entry_index, red, green, blue, output ready);
endinterface

interface npcs_out_if;
  import npcs_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] nearest_index;
  modport source(output valid, nearest_index, input ready);
  modport sink(input valid, nearest_index, output ready);
endinterface

interface npcs_cfg_if;
  import npcs_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] darkening_amount;
  modport source(output valid, darkening_amount, input ready);
  modport sink(input valid, darkening_amount, output ready);
endinterface

// ===== rtl/nearest_palette_color_search_core.sv =====
// Nearest palette colour search core: top level with the query sequencer.
// Depends on npcs_pkg, npcs_if, npcs_palette_ram, npcs_dist_scan and the macros header.
//
// A write word (func 0) stores one RGB palette entry. A nearest query (func 1) scans the
// first min(PALETTE_ENTRIES, 256) entries through the single read port of the palette
// memory, one entry per cycle; a darken query (func 2) first reads its entry. Ties go to
// the lowest index. The palette is not cleared after reset: every scanned entry must be
// written before the first query. The result sits in an output register, so the next
// word is taken while it waits. darkening_amount resets to 80.
`timescale 1ns / 1ps
`include "nearest_palette_color_search_core_macros.svh"
module nearest_palette_color_search_core import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  npcs_in_if.sink  in_chan,
  npcs_out_if.source out_chan,
  npcs_cfg_if.sink cfg_chan
);

  localparam int AW       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int SCAN_LEN = (PALETTE_ENTRIES < INDEX_REACH) ? PALETTE_ENTRIES : INDEX_REACH;
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_LEN - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DARK,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  state_t           state_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [CH_W-1:0]  dark_amt_r;
  npcs_rgb_t        target_r;
  logic             idx_ok_r;
  logic [IDX_W-1:0] scan_cnt_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_last_r;

  logic             in_acc;
  logic             query_acc;
  logic             cfg_acc;
  logic             out_free;
  logic             out_load;
  logic             idx_in_range;
  logic             scan_last;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  npcs_rgb_t        mem_wdata;
  npcs_rgb_t        mem_rdata;
  npcs_scan_ctl_t   scan_ctl;
  logic             scan_done;
  logic [IDX_W-1:0] best_idx;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign query_acc      = in_acc && ((in_chan.func == FUNC_NEAREST) ||
                                     (in_chan.func == FUNC_DARKEN));
  assign cfg_acc        = cfg_chan.valid && cfg_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign out_load       = out_free && (((state_r == ST_DRAIN) && scan_done) ||
                                       (state_r == ST_OUT));
  assign idx_in_range   = (32'(in_chan.entry_index) < PALETTE_ENTRIES);
  assign scan_last      = (scan_cnt_r == SCAN_LAST);

  assign mem_wdata = '{red: in_chan.red, green: in_chan.green, blue: in_chan.blue};
  assign mem_we    = in_acc && (in_chan.func == FUNC_WRITE) && idx_in_range;
  assign mem_re    = (in_acc && (in_chan.func == FUNC_DARKEN)) || (state_r == ST_SCAN);
  assign mem_raddr = (state_r == ST_IDLE) ? AW'(in_chan.entry_index) : AW'(scan_cnt_r);

  assign scan_ctl.clear = (state_r == ST_SCAN) && (scan_cnt_r == '0);
  assign scan_ctl.vld   = rd_vld_r;
  assign scan_ctl.last  = rd_last_r;
  assign scan_ctl.idx   = rd_idx_r;

  npcs_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_chan.entry_index)),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  npcs_dist_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .target     (target_r),
    .entry      (mem_rdata),
    .done       (scan_done),
    .best_index (best_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      dark_amt_r  <= DARKEN_RESET;
    end else begin
      rd_vld_r <= (state_r == ST_SCAN);
      if (cfg_acc) begin
        dark_amt_r <= cfg_chan.darkening_amount;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_chan.func)
              FUNC_NEAREST: begin
                target_r <= mem_wdata;
                state_r  <= ST_SCAN;
              end
              FUNC_DARKEN: begin
                idx_ok_r <= idx_in_range;
                state_r  <= ST_DARK;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DARK: begin
          if (idx_ok_r) begin
            target_r.red   <= sat_sub(mem_rdata.red, dark_amt_r);
            target_r.green <= sat_sub(mem_rdata.green, dark_amt_r);
            target_r.blue  <= sat_sub(mem_rdata.blue, dark_amt_r);
          end else begin
            target_r <= '0;
          end
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (scan_done) begin
            if (out_free) begin
              out_idx_r <= best_idx;
              state_r   <= ST_IDLE;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_idx_r <= best_idx;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r <= (state_r == ST_SCAN) ? (scan_cnt_r + 1'b1) : '0;
    rd_idx_r   <= scan_cnt_r;
    rd_last_r  <= scan_last;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.nearest_index = out_idx_r;

  `NPCS_ASSERT(a_query_blocks_input, query_acc |=> !in_chan.ready, "query did not block the input")
  `NPCS_ASSERT(a_done_in_drain, scan_done |-> (state_r == ST_DRAIN), "scan finished outside drain")
  `NPCS_ASSERT(a_read_in_scan, rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN), "stray read")
  `NPCS_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_chan.valid, "result word valid after reset")

endmodule

// ===== rtl/npcs_palette_ram.sv =====
// Palette memory: one write port, one read port, registered read data.
// Depends on npcs_pkg.
`timescale 1ns / 1ps
module npcs_palette_ram import npcs_pkg::*; #(
  parameter int  ENTRIES = PALETTE_ENTRIES_DEF,
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  npcs_rgb_t     wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output npcs_rgb_t     rdata
);

  npcs_rgb_t palette_r [ENTRIES];
  npcs_rgb_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      palette_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= palette_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/npcs_dist_scan.sv =====
// Distance stage and running minimum of the palette scan.
// Depends on npcs_pkg.
`timescale 1ns / 1ps
module npcs_dist_scan import npcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  npcs_scan_ctl_t   ctl,
  input  npcs_rgb_t        target,
  input  npcs_rgb_t        entry,
  output logic             done,
  output logic [IDX_W-1:0] best_index
);

  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] s1_dist_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_vld_r;
  logic              s1_last_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              done_r;

  assign dist_nxt = DIST_W'(abs_diff(entry.red, target.red))
                  + DIST_W'(abs_diff(entry.green, target.green))
                  + DIST_W'(abs_diff(entry.blue, target.blue));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= ctl.vld;
      done_r   <= s1_vld_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dist_r <= dist_nxt;
    s1_idx_r  <= ctl.idx;
    s1_last_r <= ctl.last;
    if (ctl.clear) begin
      best_dist_r <= '1;
    end else if (s1_vld_r && (s1_dist_r < best_dist_r)) begin
      best_dist_r <= s1_dist_r;
      best_idx_r  <= s1_idx_r;
    end
  end

  assign done       = done_r;
  assign best_index = best_idx_r;

endmodule
